// File: rtl/core/kpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_pkg - shared types and constants of the keypad scanner
// Register indexes, reset values, key codes and the key decode function.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int unsigned SETTLE_W = 16;
    localparam int unsigned HIT_W    = 7;
    localparam int unsigned CHECK_W  = 8;
    localparam int unsigned ROW_W    = 4;
    localparam int unsigned COL_W    = 4;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE_TICKS  = 2'd0,
        REG_DEBOUNCE_HITS = 2'd1,
        REG_CHECK_LIMIT   = 2'd2
    } t_cfg_reg;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 16'd10000;
    localparam logic [HIT_W-1:0]    DEBOUNCE_RESET = 7'd50;
    localparam logic [CHECK_W-1:0]  CHECK_RESET    = 8'd101;
    localparam logic [HIT_W-1:0]    HIT_MAX        = 7'h7F;

    localparam logic [CODE_W-1:0] KEY_NONE = 4'd12;
    localparam logic [CODE_W-1:0] KEY_SET  = 4'd10;
    localparam logic [CODE_W-1:0] KEY_GO   = 4'd11;
    localparam logic [CODE_W-1:0] KEY_MULTI = 4'd0;

    localparam logic [COL_W-1:0] COL_FIRST = 4'b1000;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ticks;
        logic [HIT_W-1:0]    debounce_hits;
        logic [CHECK_W-1:0]  check_limit;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]  column_drive;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } t_result;

    // latched column is 1..4 (0 = nothing latched), rows must be one-hot
    function automatic logic [CODE_W-1:0] decode_key(
        input logic [2:0]       col,
        input logic [ROW_W-1:0] rows
    );
        logic [CODE_W-1:0] code;
        logic [1:0]        c;
        logic [1:0]        r;
        logic              one_hot;
        c       = 2'(col - 3'd1);
        r       = 2'd0;
        one_hot = 1'b1;
        case (rows)
            4'b0001: r = 2'd0;
            4'b0010: r = 2'd1;
            4'b0100: r = 2'd2;
            4'b1000: r = 2'd3;
            default: one_hot = 1'b0;
        endcase
        if (c == 2'd3) begin
            code = KEY_NONE;
        end else if (r == 2'd3) begin
            case (c)
                2'd0:    code = KEY_SET;
                2'd1:    code = 4'd0;
                default: code = KEY_GO;
            endcase
        end else begin
            code = CODE_W'({2'b00, r} * 4'd3 + {2'b00, c} + 4'd1);
        end
        if (col == 3'd0 || col > 3'd4) begin
            code = KEY_NONE;
        end else if (!one_hot) begin
            code = KEY_MULTI;
        end
        return code;
    endfunction

endpackage : kpd_pkg
`default_nettype wire

// File: rtl/core/kpd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_in_if - row sample channel
// One beat per scan tick, carrying the sampled row lines.
// ----------------------------------------------------------------------------
interface kpd_in_if;
    logic                     valid;
    logic                     ready;
    logic [kpd_pkg::ROW_W-1:0] row_lines;

    modport source (output valid, output row_lines, input ready);
    modport sink   (input valid, input row_lines, output ready);
endinterface : kpd_in_if
`default_nettype wire

// File: rtl/core/kpd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_out_if - scan result channel
// One beat per tick: column drive, key valid flag and key code.
// ----------------------------------------------------------------------------
interface kpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [kpd_pkg::COL_W-1:0]  column_drive;
    logic                       key_valid;
    logic [kpd_pkg::CODE_W-1:0] key_code;

    modport source (output valid, output column_drive, output key_valid,
                    output key_code, input ready);
    modport sink   (input valid, input column_drive, input key_valid,
                    input key_code, output ready);
endinterface : kpd_out_if
`default_nettype wire

// File: rtl/core/kpd_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_scan - column scan and debounce state
// Holds the scan state and advances it by one tick on each accepted beat.
// ----------------------------------------------------------------------------
module kpd_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [kpd_pkg::ROW_W-1:0] i_rows,
    input  wire kpd_pkg::t_cfg             i_cfg,
    output kpd_pkg::t_result               o_result
);
    import kpd_pkg::*;

    logic [1:0]          r_col_idx,    n_col_idx;
    logic                r_checking,   n_checking;
    logic [SETTLE_W-1:0] r_settle_cnt, n_settle_cnt;
    logic [CHECK_W-1:0]  r_check_cnt,  n_check_cnt;
    logic [HIT_W-1:0]    r_hit_cnt,    n_hit_cnt;
    logic [2:0]          r_lat_col,    n_lat_col;
    logic [ROW_W-1:0]    r_lat_rows,   n_lat_rows;

    logic               col_end;
    logic               done;
    logic [CHECK_W-1:0] limit;
    logic [CHECK_W-1:0] chk_inc;
    logic [HIT_W-1:0]   hit_upd;

    always_comb begin
        n_col_idx    = r_col_idx;
        n_checking   = r_checking;
        n_settle_cnt = r_settle_cnt;
        n_check_cnt  = r_check_cnt;
        n_hit_cnt    = r_hit_cnt;
        n_lat_col    = r_lat_col;
        n_lat_rows   = r_lat_rows;
        col_end      = 1'b0;
        limit        = (i_cfg.check_limit == '0) ? CHECK_W'(1) : i_cfg.check_limit;
        chk_inc      = r_check_cnt + CHECK_W'(1);
        hit_upd      = '0;

        if (!r_checking) begin
            if (r_settle_cnt < i_cfg.settle_ticks) begin
                n_settle_cnt = r_settle_cnt + SETTLE_W'(1);
            end else if (i_rows != '0) begin
                n_checking  = 1'b1;
                n_check_cnt = '0;
            end else begin
                col_end = 1'b1;
            end
        end else begin
            n_check_cnt = chk_inc;
            if (i_rows != '0) begin
                hit_upd    = (r_hit_cnt < HIT_MAX) ? r_hit_cnt + HIT_W'(1) : r_hit_cnt;
                n_lat_col  = {1'b0, r_col_idx} + 3'd1;
                n_lat_rows = i_rows;
            end
            n_hit_cnt = hit_upd;
            if (hit_upd >= i_cfg.debounce_hits || chk_inc >= limit) begin
                col_end = 1'b1;
            end
        end

        done = col_end && (r_col_idx == 2'd3);
        if (col_end && !done) begin
            n_col_idx    = r_col_idx + 2'd1;
            n_checking   = 1'b0;
            n_settle_cnt = '0;
            n_check_cnt  = '0;
        end

        o_result.column_drive = COL_FIRST >> r_col_idx;
        o_result.key_valid    = done;
        o_result.key_code     = done ? decode_key(n_lat_col, n_lat_rows) : '0;

        // scan restart
        if (done) begin
            n_col_idx    = '0;
            n_checking   = 1'b0;
            n_settle_cnt = '0;
            n_check_cnt  = '0;
            n_hit_cnt    = '0;
            n_lat_col    = '0;
            n_lat_rows   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx    <= '0;
            r_checking   <= 1'b0;
            r_settle_cnt <= '0;
            r_check_cnt  <= '0;
            r_hit_cnt    <= '0;
            r_lat_col    <= '0;
            r_lat_rows   <= '0;
        end else if (i_step) begin
            r_col_idx    <= n_col_idx;
            r_checking   <= n_checking;
            r_settle_cnt <= n_settle_cnt;
            r_check_cnt  <= n_check_cnt;
            r_hit_cnt    <= n_hit_cnt;
            r_lat_col    <= n_lat_col;
            r_lat_rows   <= n_lat_rows;
        end
    end

endmodule : kpd_scan
`default_nettype wire

// File: rtl/core/matrix_keypad_scan_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce - 4x4 keypad column scanner with debounce
// Each input beat is one scan tick with the sampled row lines. Every tick
// gives one output beat: the column driven during that tick, and on the tick
// that ends a scan key_valid with the decoded key (1-9, 0, 10 SET, 11 GO,
// 12 letter or no key, 0 for several rows at once).
// Configuration: settle time, debounce hit count and check limit, written on
// the plain write port while the block is idle, a rule on the user that the
// block itself does not enforce; effective from the next beat. Each output
// beat comes in the cycle after its input beat, from an output register.
// Throughput: one beat per cycle, set by the state update in kpd_scan. While
// the output register is full and the receiver stalls, the input is held
// off; a beat is taken in the same cycle the pending result leaves.
// Reset: synchronous, active low; scan restarts at column one in the settle
// phase, registers return to 10000 / 50 / 101, the output register empties.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    kpd_in_if.sink                             i_row,
    kpd_out_if.source                          o_key,
    input  wire logic                          i_cfg_we,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kpd_pkg::CFG_W-1:0]     i_cfg_data
);
    import kpd_pkg::*;

    t_cfg    r_cfg;
    t_result scan_res;
    t_result r_out;
    logic    r_out_valid;
    logic    in_take;

    assign i_row.ready = !r_out_valid || o_key.ready;
    assign in_take     = i_row.valid && i_row.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks  <= SETTLE_RESET;
            r_cfg.debounce_hits <= DEBOUNCE_RESET;
            r_cfg.check_limit   <= CHECK_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_SETTLE_TICKS:  r_cfg.settle_ticks  <= i_cfg_data;
                REG_DEBOUNCE_HITS: r_cfg.debounce_hits <= i_cfg_data[HIT_W-1:0];
                REG_CHECK_LIMIT:   r_cfg.check_limit   <= i_cfg_data[CHECK_W-1:0];
                default: ;
            endcase
        end
    end

    kpd_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_take),
        .i_rows   (i_row.row_lines),
        .i_cfg    (r_cfg),
        .o_result (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_key.ready) begin
            r_out_valid <= 1'b0;
        end
        if (in_take) begin
            r_out <= scan_res;
        end
    end

    assign o_key.valid        = r_out_valid;
    assign o_key.column_drive = r_out.column_drive;
    assign o_key.key_valid    = r_out.key_valid;
    assign o_key.key_code     = r_out.key_code;

    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.valid |-> $onehot(o_key.column_drive))
        else $error("column drive not one-hot");

    a_code_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.valid && !o_key.key_valid |-> o_key.key_code == '0)
        else $error("key code set without key valid");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.valid && o_key.key_valid |-> o_key.key_code <= KEY_NONE)
        else $error("key code out of range");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_key.valid)
        else $error("accepted beat gave no result");

endmodule : matrix_keypad_scan_debounce
`default_nettype wire
